// ----- hw/rtl/flpa_pkg.sv -----
`default_nettype none
package flpa_pkg;

    localparam int PAGE_W  = 16;
    localparam int REQ_W   = 2;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'd1;

    localparam logic [PAGE_W-1:0] FIRST_FREE_RESET = 16'd0;
    localparam logic [CFG_W-1:0]  END_PAGE_RESET   = 17'd65536;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REBUILD = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic pop;
        logic walk;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic head_null;
        logic walk_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- hw/rtl/flpa_req_if.sv -----
`default_nettype none
interface flpa_req_if;
    logic                         valid;
    logic                         ready;
    logic [flpa_pkg::REQ_W-1:0]   req_type;
    logic [flpa_pkg::PAGE_W-1:0]  page_in;
    logic                         page_is_null;

    modport source (output valid, output req_type, output page_in, output page_is_null,
                    input ready);
    modport sink   (input valid, input req_type, input page_in, input page_is_null,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/flpa_rsp_if.sv -----
`default_nettype none
interface flpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [flpa_pkg::PAGE_W-1:0]  page_out;
    logic                         none_free;
    logic                         bad_page;

    modport source (output valid, output page_out, output none_free, output bad_page,
                    input ready);
    modport sink   (input valid, input page_out, input none_free, input bad_page,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/flpa_ctrl.sv -----
`default_nettype none
module flpa_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [flpa_pkg::REQ_W-1:0]  i_req_type,
    input  wire flpa_pkg::t_status           i_status,
    output      logic                        o_in_ready,
    output      flpa_pkg::t_cmd              o_cmd
);

    flpa_pkg::t_state r_state;
    flpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            flpa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    case (i_req_type)
                        flpa_pkg::REQ_ALLOC:   n_state = i_status.head_null ?
                                                         flpa_pkg::S_EMIT : flpa_pkg::S_POP;
                        flpa_pkg::REQ_REBUILD: n_state = flpa_pkg::S_WALK;
                        default:               n_state = flpa_pkg::S_EMIT;
                    endcase
                end
            end
            flpa_pkg::S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = flpa_pkg::S_EMIT;
            end
            flpa_pkg::S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = flpa_pkg::S_EMIT;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            flpa_pkg::S_EMIT: begin
                // wait here only while the previous result is still unclaimed
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = flpa_pkg::S_IDLE;
                end
            end
            default: n_state = flpa_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/flpa_datapath.sv -----
`default_nettype none
module flpa_datapath #(
    parameter int NUM_PAGES = 65536
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire flpa_pkg::t_cmd                  i_cmd,
    output      flpa_pkg::t_status               o_status,
    input  wire logic [flpa_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [flpa_pkg::PAGE_W-1:0]     i_page_in,
    input  wire logic                            i_page_is_null,
    input  wire logic                            i_cfg_we,
    input  wire logic [flpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [flpa_pkg::CFG_W-1:0]      i_cfg_data,
    output      logic [flpa_pkg::PAGE_W-1:0]     o_page_out,
    output      logic                            o_none_free,
    output      logic                            o_bad_page,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int CW  = flpa_pkg::CFG_W;
    localparam int PGW = flpa_pkg::PAGE_W;
    // wide enough for page counts, the end register and the parameter itself
    localparam int WW  = (PW + 1 > CW) ? PW + 1 : CW;

    // link entry: {null, page}
    logic [PW:0]     mem [NUM_PAGES];
    logic [PW:0]     r_rd;

    logic [PGW-1:0]  r_first;
    logic [CW-1:0]   r_end;
    logic            r_head_null;
    logic [PW-1:0]   r_head;
    logic [WW-1:0]   r_walk;

    logic [PGW-1:0]  r_pend_page;
    logic            r_pend_none;
    logic            r_pend_bad;
    logic            r_out_valid;
    logic [PGW-1:0]  r_out_page;
    logic            r_out_none;
    logic            r_out_bad;

    logic [WW-1:0]   win_end;
    logic [WW-1:0]   page_w;
    logic            in_window;
    logic            do_free;
    logic            mem_we;
    logic [PW-1:0]   mem_wa;
    logic            mem_re;

    always_comb begin
        win_end   = (WW'(r_end) < WW'(NUM_PAGES)) ? WW'(r_end) : WW'(NUM_PAGES);
        page_w    = WW'(i_page_in);
        in_window = (page_w >= WW'(r_first)) && (page_w < win_end);
        do_free   = i_cmd.start && (i_req_type == flpa_pkg::REQ_FREE) &&
                    !i_page_is_null && in_window;
        mem_we    = do_free || i_cmd.walk;
        mem_wa    = i_cmd.walk ? r_walk[PW-1:0] : page_w[PW-1:0];
        mem_re    = i_cmd.start && (i_req_type == flpa_pkg::REQ_ALLOC) && !r_head_null;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= {r_head_null, r_head};
        end
        if (mem_re) begin
            r_rd <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= flpa_pkg::FIRST_FREE_RESET;
            r_end       <= flpa_pkg::END_PAGE_RESET;
            r_head_null <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    flpa_pkg::CFG_FIRST_FREE: r_first <= i_cfg_data[PGW-1:0];
                    flpa_pkg::CFG_END_PAGE:   r_end   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.start) begin
                r_pend_page <= '0;
                r_pend_none <= 1'b0;
                r_pend_bad  <= 1'b0;
                case (i_req_type)
                    flpa_pkg::REQ_ALLOC: begin
                        if (r_head_null) begin
                            r_pend_none <= 1'b1;
                        end else begin
                            r_pend_page <= PGW'(r_head);
                        end
                    end
                    flpa_pkg::REQ_FREE: begin
                        r_pend_bad <= !i_page_is_null && !in_window;
                        if (do_free) begin
                            r_head_null <= 1'b0;
                            r_head      <= page_w[PW-1:0];
                        end
                    end
                    flpa_pkg::REQ_REBUILD: begin
                        r_head_null <= 1'b1;
                        r_walk      <= WW'(r_first);
                    end
                    default: ;
                endcase
            end

            if (i_cmd.pop) begin
                r_head_null <= r_rd[PW];
                r_head      <= r_rd[PW-1:0];
            end

            if (i_cmd.walk) begin
                r_head_null <= 1'b0;
                r_head      <= r_walk[PW-1:0];
                r_walk      <= r_walk + WW'(1);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out_page  <= r_pend_page;
                r_out_none  <= r_pend_none;
                r_out_bad   <= r_pend_bad;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.head_null = r_head_null;
    assign o_status.walk_done = (r_walk >= win_end);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_page_out  = r_out_page;
    assign o_none_free = r_out_none;
    assign o_bad_page  = r_out_bad;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- hw/rtl/free_list_page_allocator_unit.sv -----
// Free-list page allocator: a LIFO list of free pages linked through a
// next-pointer RAM of NUM_PAGES entries, with the head held in a register.
// i_req (sink): one beat per request: allocate, free or rebuild.
// o_rsp (source): exactly one beat per request, in request order.
// Config: i_cfg_we / i_cfg_idx / i_cfg_data write first_free_page (index 0)
// or end_page (index 1); write only while no request is in flight.
// Path of each request through the controller states:
//   free, ignored free and the other codes: straight on to EMIT;
//   allocate: POP (registered RAM read of the head's link), skipped on an empty list;
//   rebuild: WALK over the whole window, one page pushed per cycle, then EMIT.
// One request is worked at a time; a new beat is taken once the previous
// result sits in the output register, so a stalled receiver holds one result
// and one more request may finish behind it before i_req.ready drops.
// Reset empties the list and restores the config defaults; the link RAM is
// not cleared, since only links of listed pages are ever read.
`default_nettype none
module free_list_page_allocator_unit #(
    parameter int NUM_PAGES = 65536
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    flpa_req_if.sink                             i_req,
    flpa_rsp_if.source                           o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [flpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [flpa_pkg::CFG_W-1:0]      i_cfg_data
);

    flpa_pkg::t_cmd    cmd;
    flpa_pkg::t_status status;

    flpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_status   (status),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    flpa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_req_type     (i_req.req_type),
        .i_page_in      (i_req.page_in),
        .i_page_is_null (i_req.page_is_null),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_page_out     (o_rsp.page_out),
        .o_none_free    (o_rsp.none_free),
        .o_bad_page     (o_rsp.bad_page),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready)
    );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

    localparam int PAGE_COUNT      = 65536;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int PHASES          = 8;
    localparam logic [flpa_pkg::REQ_W-1:0] REQ_NOP = 2'd3;
    localparam logic [16:0] LINK_END = 17'h10000;

    typedef struct packed {
        logic [flpa_pkg::PAGE_W-1:0] page;
        logic                        none_free;
        logic                        bad_page;
    } t_grant;

    typedef struct packed {
        logic                        is_cfg;
        logic [flpa_pkg::REQ_W-1:0]  code;
        logic [flpa_pkg::PAGE_W-1:0] page;
        logic                        is_null;
        logic                        typed;
        t_grant                      want;
        logic [flpa_pkg::CFG_W-1:0]  first_data;
        logic [flpa_pkg::CFG_W-1:0]  end_data;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [flpa_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [flpa_pkg::CFG_W-1:0] i_cfg_data;

    flpa_req_if req_if ();
    flpa_rsp_if rsp_if ();

    free_list_page_allocator_unit #(.NUM_PAGES(PAGE_COUNT)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // allocator shadow state
    logic [16:0]                 link_model [PAGE_COUNT];
    logic [16:0]                 head_model;
    logic [flpa_pkg::PAGE_W-1:0] first_model;
    logic [flpa_pkg::CFG_W-1:0]  end_model;

    t_grant                      pending_grants [$];
    logic [flpa_pkg::PAGE_W-1:0] held_pages [$];

    int cycle_count = 0;
    int grants_checked = 0;
    int grant_errors = 0;
    int reqs_sent = 0;
    int pages_granted = 0;
    int empty_allocs = 0;
    int bad_frees = 0;
    int rebuilds = 0;
    int window_writes = 0;
    int burst_left = 0;
    int rsp_run = 0;

    function automatic t_grant predict_request(logic [flpa_pkg::REQ_W-1:0] code,
                                               logic [flpa_pkg::PAGE_W-1:0] pg, logic nul);
        t_grant g;
        int     stop_pg;
        g = '0;
        stop_pg = (end_model < PAGE_COUNT) ? int'(end_model) : PAGE_COUNT;
        case (code)
            flpa_pkg::REQ_ALLOC: begin
                if (head_model[16]) begin
                    g.none_free = 1'b1;
                end else begin
                    g.page = head_model[15:0];
                    head_model = link_model[head_model[15:0]];
                end
            end
            flpa_pkg::REQ_FREE: begin
                if (!nul) begin
                    if (int'(pg) < int'(first_model) || int'(pg) >= stop_pg) begin
                        g.bad_page = 1'b1;
                    end else begin
                        link_model[pg] = head_model;
                        head_model = {1'b0, pg};
                    end
                end
            end
            flpa_pkg::REQ_REBUILD: begin
                // ascending push, so the top page of the window ends up at the head
                head_model = LINK_END;
                for (int p = int'(first_model); p < stop_pg; p++) begin
                    link_model[p] = head_model;
                    head_model = p[16:0];
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        grant_errors++;
        if (grant_errors <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function automatic t_step known_row(logic [flpa_pkg::REQ_W-1:0] code,
                                        logic [flpa_pkg::PAGE_W-1:0] pg, logic nul,
                                        logic [flpa_pkg::PAGE_W-1:0] out_pg, logic none,
                                        logic bad);
        t_step s;
        s = '0;
        s.code = code;
        s.page = pg;
        s.is_null = nul;
        s.typed = 1'b1;
        s.want.page = out_pg;
        s.want.none_free = none;
        s.want.bad_page = bad;
        return s;
    endfunction

    function automatic t_step window_row(logic [flpa_pkg::CFG_W-1:0] first_data,
                                         logic [flpa_pkg::CFG_W-1:0] end_data);
        t_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.first_data = first_data;
        s.end_data = end_data;
        return s;
    endfunction

    task automatic send_request(input logic [flpa_pkg::REQ_W-1:0] code,
                                input logic [flpa_pkg::PAGE_W-1:0] pg,
                                input logic nul, input logic typed, input t_grant want);
        t_grant g;
        if (burst_left <= 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= code;
        req_if.page_in      <= pg;
        req_if.page_is_null <= nul;
        do @(posedge i_clk); while (!req_if.ready);
        burst_left--;
        g = predict_request(code, pg, nul);
        pending_grants.push_back(typed ? want : g);
        reqs_sent++;
        if (code == flpa_pkg::REQ_ALLOC) begin
            if (g.none_free) empty_allocs++;
            else begin
                pages_granted++;
                held_pages.push_back(g.page);
            end
        end
        if (code == flpa_pkg::REQ_REBUILD) begin
            rebuilds++;
            held_pages.delete();
        end
        if (g.bad_page) bad_frees++;
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [flpa_pkg::CFG_W-1:0] first_data,
                                input logic [flpa_pkg::CFG_W-1:0] end_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= flpa_pkg::CFG_FIRST_FREE;
        i_cfg_data <= first_data;
        @(posedge i_clk);
        i_cfg_idx  <= flpa_pkg::CFG_END_PAGE;
        i_cfg_data <= end_data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        first_model = first_data[flpa_pkg::PAGE_W-1:0];
        end_model = end_data;
        window_writes++;
    endtask

    // receiver: alternating ready and stall runs, some stalls of a single cycle
    always @(posedge i_clk) begin
        if (rsp_run == 0) begin
            if (rsp_if.ready) begin
                rsp_if.ready <= 1'b0;
                rsp_run <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                rsp_if.ready <= 1'b1;
                rsp_run <= $urandom_range(1, 30);
            end
        end else begin
            rsp_run <= rsp_run - 1;
        end
    end

    always @(posedge i_clk) begin : grant_check
        t_grant want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_grants.size() == 0) begin
                note_mismatch("beat with nothing pending", 0, 32'(rsp_if.page_out));
            end else begin
                want = pending_grants.pop_front();
                grants_checked++;
                if (rsp_if.page_out !== want.page)
                    note_mismatch("page_out", 32'(want.page), 32'(rsp_if.page_out));
                if (rsp_if.none_free !== want.none_free)
                    note_mismatch("none_free", 32'(want.none_free), 32'(rsp_if.none_free));
                if (rsp_if.bad_page !== want.bad_page)
                    note_mismatch("bad_page", 32'(want.bad_page), 32'(rsp_if.bad_page));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d results pending", pending_grants.size());
            $display("[free_list_page_allocator_unit] ERROR");
            $finish;
        end
    end

    initial begin
        t_step                       steps [$];
        int                          first_pg;
        int                          end_pg;
        int                          useful;
        int                          r;
        int                          idx;
        logic                        paused;
        logic                        spare_bit;
        logic [flpa_pkg::REQ_W-1:0]  code;
        logic [flpa_pkg::PAGE_W-1:0] pg;
        logic                        nul;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = flpa_pkg::CFG_FIRST_FREE;
        i_cfg_data          = '0;
        req_if.valid        = 1'b0;
        req_if.req_type     = flpa_pkg::REQ_ALLOC;
        req_if.page_in      = '0;
        req_if.page_is_null = 1'b0;
        rsp_if.ready        = 1'b0;
        head_model          = LINK_END;
        first_model         = flpa_pkg::FIRST_FREE_RESET;
        end_model           = flpa_pkg::END_PAGE_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window [0, 65536), list empty
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd0,    1'b1, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_FREE,    16'hFFFF,  1'b1, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(REQ_NOP,               16'd0,     1'b0, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_FREE,    16'hFFFF,  1'b0, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_FREE,    16'd0,     1'b0, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'hFFFF, 1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd0,    1'b1, 1'b0));
        // one-page window at the very top
        steps.push_back(window_row(17'd65535, 17'd65536));
        steps.push_back(known_row(flpa_pkg::REQ_REBUILD, 16'd0,     1'b0, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_FREE,    16'd65534, 1'b0, 16'd0,    1'b0, 1'b1));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'hFFFF, 1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd0,    1'b1, 1'b0));
        // end below start: empty window
        steps.push_back(window_row(17'd10, 17'd5));
        steps.push_back(known_row(flpa_pkg::REQ_REBUILD, 16'd0,     1'b0, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd0,    1'b1, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_FREE,    16'd7,     1'b0, 16'd0,    1'b0, 1'b1));
        steps.push_back(window_row(17'd0, 17'd4));
        steps.push_back(known_row(flpa_pkg::REQ_REBUILD, 16'd0,     1'b0, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd3,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd2,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_FREE,    16'd4,     1'b0, 16'd0,    1'b0, 1'b1));
        steps.push_back(known_row(flpa_pkg::REQ_FREE,    16'd3,     1'b0, 16'd0,    1'b0, 1'b0));
        // new window without rebuild: listed pages stay, range check follows the new window
        steps.push_back(window_row(17'd2, 17'd0));
        steps.push_back(known_row(flpa_pkg::REQ_FREE,    16'd0,     1'b0, 16'd0,    1'b0, 1'b1));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd3,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd1,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd0,    1'b0, 1'b0));
        steps.push_back(known_row(flpa_pkg::REQ_ALLOC,   16'd0,     1'b0, 16'd0,    1'b1, 1'b0));

        foreach (steps[i]) begin
            if (steps[i].is_cfg) begin
                wait_idle();
                write_window(steps[i].first_data, steps[i].end_data);
            end else begin
                send_request(steps[i].code, steps[i].page, steps[i].is_null,
                             steps[i].typed, steps[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    first_pg = 0;
                    end_pg = PAGE_COUNT;
                end
                1: begin
                    end_pg = PAGE_COUNT;
                    first_pg = PAGE_COUNT - $urandom_range(1, 40);
                end
                2: begin
                    first_pg = $urandom_range(1000, 65535);
                    end_pg = $urandom_range(0, first_pg);
                end
                3: begin
                    first_pg = $urandom_range(0, 60000);
                    end_pg = first_pg + $urandom_range(512, 2048);
                end
                default: begin
                    first_pg = $urandom_range(0, 65000);
                    end_pg = first_pg + $urandom_range(1, 48);
                end
            endcase
            wait_idle();
            // top bit of the first-page write is dropped by the 16-bit register
            spare_bit = 1'($urandom_range(0, 1));
            write_window({spare_bit, first_pg[15:0]}, end_pg[16:0]);
            if (ph < 3 || $urandom_range(0, 3) != 0)
                send_request(flpa_pkg::REQ_REBUILD, 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)), 1'b0, '0);

            useful = 0;
            paused = 1'b0;
            while (useful < ITEMS_PER_PHASE) begin
                if (!paused && useful == ITEMS_PER_PHASE / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                nul = 1'b0;
                pg = 16'($urandom_range(0, 65535));
                if (r < 45 || (r < 80 && held_pages.size() == 0)) begin
                    code = flpa_pkg::REQ_ALLOC;
                end else if (r < 80) begin
                    // return a page this run was granted
                    idx = $urandom_range(0, held_pages.size() - 1);
                    code = flpa_pkg::REQ_FREE;
                    pg = held_pages[idx];
                    held_pages.delete(idx);
                end else if (r < 86) begin
                    code = flpa_pkg::REQ_FREE;
                end else if (r < 92) begin
                    code = flpa_pkg::REQ_FREE;
                    nul = 1'b1;
                end else if (r < 95) begin
                    code = REQ_NOP;
                end else if (r < 97 && end_pg - first_pg <= 2048) begin
                    code = flpa_pkg::REQ_REBUILD;
                end else begin
                    // just outside either window edge, or a random page if the window spans all pages
                    code = flpa_pkg::REQ_FREE;
                    if (first_pg > 0 && (r % 2 == 0 || end_pg >= PAGE_COUNT))
                        pg = 16'(first_pg - 1);
                    else if (end_pg < PAGE_COUNT)
                        pg = end_pg[15:0];
                end
                send_request(code, pg, nul, 1'b0, '0);
                if (code != REQ_NOP && !(code == flpa_pkg::REQ_FREE && nul))
                    useful++;
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("%0d requests over %0d windows: %0d pages granted, %0d empty allocs,",
                 reqs_sent, window_writes, pages_granted, empty_allocs);
        $display("%0d out-of-window frees, %0d rebuilds, %0d result beats checked, %0d mismatches",
                 bad_frees, rebuilds, grants_checked, grant_errors);
        if (grant_errors == 0 && pending_grants.size() == 0)
            $display("[free_list_page_allocator_unit] OK");
        else
            $display("[free_list_page_allocator_unit] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/flpa_pkg.sv
hw/rtl/flpa_req_if.sv
hw/rtl/flpa_rsp_if.sv
hw/rtl/flpa_ctrl.sv
hw/rtl/flpa_datapath.sv
hw/rtl/free_list_page_allocator_unit.sv
tb/sv/testbench.sv
